### rtl/dpq_pkg.sv
// Package with constants, codes and types of the due-date priority queue.
package dpq_pkg;

  // Default sizes
  localparam int unsigned DefaultDepth   = 16;
  localparam int unsigned DefaultTagBits = 16;

  // Field limits
  localparam int unsigned MonthBits = 4;
  localparam int unsigned DayInBits = 6;
  localparam int unsigned DayBits   = 5;
  localparam int unsigned LenBits   = 8;
  localparam int unsigned KeyBits   = MonthBits + DayBits;

  localparam logic [MonthBits-1:0] MaxMonth = 4'd12;
  localparam logic [DayInBits-1:0] MaxDay   = 6'd31;
  localparam logic [LenBits-1:0]   MaxLen   = 8'd12;

  // Request codes
  typedef enum logic {
    OpEnqueue = 1'b0,
    OpDequeue = 1'b1
  } op_e;

  // Result status codes
  typedef enum logic [1:0] {
    StatusOk      = 2'd0,
    StatusInvalid = 2'd1,
    StatusFull    = 2'd2,
    StatusEmpty   = 2'd3
  } status_e;

  // Sequencer states
  typedef enum logic [2:0] {
    StIdle,
    StDeqRd,
    StEnqCmp,
    StEnqWr,
    StResp
  } state_e;

endpackage

### rtl/due_date_priority_queue_top.sv
// Top level of the due-date priority queue: circular sorted store and sequencer.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+-----------------------------------------
//   in      | input     | in_valid_i / in_stall_o | op, due_month, due_day, course_length,
//           |           |                        | item_tag
//   out     | output    | out_valid_o/out_stall_i | accepted, status, out_tag, out_month,
//           |           |                        | out_day
//
// Each request gives one result. A rejected request goes from StIdle straight to StResp, a
// dequeue passes through StDeqRd, and an enqueue passes through StEnqCmp and/or StEnqWr, where
// each stored entry with a later date moves up one slot; each move is one read/compare/write
// of the one-write, one-read store. The input stalls while a request is in the sequencer.
// Reset empties the queue at once; store contents are left as they are.
// A held result keeps its register until taken; the sequencer waits for the slot.
module due_date_priority_queue_top #(
  parameter int unsigned DEPTH    = dpq_pkg::DefaultDepth,
  parameter int unsigned TAG_BITS = dpq_pkg::DefaultTagBits
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  logic                          op_i,
  input  logic [dpq_pkg::MonthBits-1:0] due_month_i,
  input  logic [dpq_pkg::DayInBits-1:0] due_day_i,
  input  logic [dpq_pkg::LenBits-1:0]   course_length_i,
  input  logic [TAG_BITS-1:0]           item_tag_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output logic                          accepted_o,
  output logic [1:0]                    status_o,
  output logic [TAG_BITS-1:0]           out_tag_o,
  output logic [dpq_pkg::MonthBits-1:0] out_month_o,
  output logic [dpq_pkg::DayBits-1:0]   out_day_o
);
  import dpq_pkg::*;

  localparam int unsigned IdxW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW   = $clog2(DEPTH + 1);
  localparam logic [IdxW-1:0] LastIdx = IdxW'(DEPTH - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(DEPTH);

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
  } entry_t;

  // Circular index helpers
  function automatic logic [IdxW-1:0] idx_next(input logic [IdxW-1:0] p);
    return (p == LastIdx) ? '0 : p + 1'b1;
  endfunction

  function automatic logic [IdxW-1:0] idx_prev(input logic [IdxW-1:0] p);
    return (p == '0) ? LastIdx : p - 1'b1;
  endfunction

  // Control state
  state_e          state_q, state_d;
  logic [IdxW-1:0] head_q, head_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [IdxW-1:0] pos_q, pos_d;
  logic [CntW-1:0] count_q, count_d;
  logic            out_valid_q, out_valid_d;

  // Payload registers
  entry_t               new_q, new_d;
  logic                 res_acc_q, res_acc_d;
  status_e              res_status_q, res_status_d;
  entry_t               res_q, res_d;
  logic                 out_acc_q;
  status_e              out_status_q;
  entry_t               out_q;
  logic                 out_load;

  // Store ports
  entry_t          mem_q [DEPTH];
  entry_t          rd_q;
  logic            we;
  logic [IdxW-1:0] waddr;
  entry_t          wdata;
  logic [IdxW-1:0] raddr;

  logic in_xfer;
  logic bad_entry;
  logic later;

  assign in_stall_o = (state_q != StIdle);
  assign in_xfer    = in_valid_i && !in_stall_o;
  assign bad_entry  = (due_month_i > MaxMonth) || (due_day_i > MaxDay) ||
                      (course_length_i == '0) || (course_length_i > MaxLen);
  assign later      = {rd_q.month, rd_q.day} > {new_q.month, new_q.day};

  // Next state, store access and result
  always_comb begin
    state_d      = state_q;
    head_d       = head_q;
    tail_d       = tail_q;
    pos_d        = pos_q;
    count_d      = count_q;
    new_d        = new_q;
    res_acc_d    = res_acc_q;
    res_status_d = res_status_q;
    res_d        = res_q;
    out_load     = 1'b0;
    we           = 1'b0;
    waddr        = pos_q;
    wdata        = new_q;
    raddr        = idx_prev(pos_q);

    case (state_q)
      StIdle: begin
        new_d.tag   = item_tag_i;
        new_d.month = due_month_i;
        new_d.day   = due_day_i[DayBits-1:0];
        res_d       = '0;
        res_acc_d   = 1'b0;
        if (op_i == OpDequeue) begin
          raddr = head_q;
        end else begin
          raddr = idx_prev(tail_q);
        end
        if (in_xfer) begin
          state_d = StResp;
          if (op_i == OpDequeue) begin
            if (count_q == '0) begin
              res_status_d = StatusEmpty;
            end else begin
              state_d = StDeqRd;
            end
          end else if (bad_entry) begin
            res_status_d = StatusInvalid;
          end else if (count_q == FullCnt) begin
            res_status_d = StatusFull;
          end else begin
            res_acc_d    = 1'b1;
            res_status_d = StatusOk;
            pos_d        = tail_q;
            tail_d       = idx_next(tail_q);
            count_d      = count_q + 1'b1;
            if (count_q == '0) begin
              state_d = StEnqWr;
            end else begin
              state_d = StEnqCmp;
            end
          end
        end
      end
      StDeqRd: begin
        // pop the head entry
        res_d        = rd_q;
        res_acc_d    = 1'b1;
        res_status_d = StatusOk;
        head_d       = idx_next(head_q);
        count_d      = count_q - 1'b1;
        state_d      = StResp;
      end
      StEnqCmp: begin
        we = 1'b1;
        if (later) begin
          // move the later entry up one slot and look one further down
          wdata = rd_q;
          pos_d = idx_prev(pos_q);
          raddr = idx_prev(pos_d);
          if (pos_d == head_q) begin
            state_d = StEnqWr;
          end
        end else begin
          state_d = StResp;
        end
      end
      StEnqWr: begin
        we      = 1'b1;
        state_d = StResp;
      end
      StResp: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  // Drop a taken result, load a new one
  always_comb begin
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    if (out_load) begin
      out_valid_d = 1'b1;
    end
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      head_q      <= '0;
      tail_q      <= '0;
      pos_q       <= '0;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      tail_q      <= tail_d;
      pos_q       <= pos_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    new_q        <= new_d;
    res_acc_q    <= res_acc_d;
    res_status_q <= res_status_d;
    res_q        <= res_d;
    if (out_load) begin
      out_acc_q    <= res_acc_q;
      out_status_q <= res_status_q;
      out_q        <= res_q;
    end
  end

  // Entry store: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[waddr] <= wdata;
    end
    rd_q <= mem_q[raddr];
  end

  assign out_valid_o = out_valid_q;
  assign accepted_o  = out_acc_q;
  assign status_o    = out_status_q;
  assign out_tag_o   = out_q.tag;
  assign out_month_o = out_q.month;
  assign out_day_o   = out_q.day;

endmodule

### tb/tb_top.sv
// Testbench of the due-date priority queue: shadow sorted queue, random traffic and stalls.
`timescale 1ns / 100ps

module tb_top;
  import dpq_pkg::*;

  localparam int unsigned DEPTH       = 16;
  localparam int unsigned TAG_BITS    = 16;
  localparam int unsigned RandomItems = 1025;
  localparam int unsigned QuietLimit  = 3000;
  localparam int unsigned DrainCycles = 30;
  localparam int unsigned ReportLimit = 10;

  typedef struct packed {
    logic [TAG_BITS-1:0]  tag;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
  } entry_t;

  typedef struct {
    logic                 accepted;
    status_e              status;
    logic [TAG_BITS-1:0]  tag;
    logic [MonthBits-1:0] month;
    logic [DayBits-1:0]   day;
  } result_t;

  // Shadow of the sorted store and the results it owes
  class queue_scoreboard;
    entry_t      sorted_entries[$];
    result_t     expected_results[$];
    int unsigned fail_count;

    function int unsigned pending();
      return expected_results.size();
    endfunction

    // Apply one accepted request to the shadow store and queue its result
    function void note_request(op_e op, logic [MonthBits-1:0] month,
                               logic [DayInBits-1:0] day, logic [LenBits-1:0] len,
                               logic [TAG_BITS-1:0] tag);
      result_t res;
      entry_t  ent;
      int      pos;
      res.accepted = 1'b0;
      res.status   = StatusOk;
      res.tag      = '0;
      res.month    = '0;
      res.day      = '0;
      if (op == OpEnqueue) begin
        if (month > MaxMonth || day > MaxDay || len == '0 || len > MaxLen) begin
          res.status = StatusInvalid;
        end else if (sorted_entries.size() >= DEPTH) begin
          res.status = StatusFull;
        end else begin
          ent.tag   = tag;
          ent.month = month;
          ent.day   = day[DayBits-1:0];
          // go behind every entry whose date is not later
          pos = 0;
          while (pos < sorted_entries.size() &&
                 {sorted_entries[pos].month, sorted_entries[pos].day} <=
                 {ent.month, ent.day})
            pos++;
          sorted_entries.insert(pos, ent);
          res.accepted = 1'b1;
        end
      end else if (sorted_entries.size() == 0) begin
        res.status = StatusEmpty;
      end else begin
        ent          = sorted_entries.pop_front();
        res.accepted = 1'b1;
        res.tag      = ent.tag;
        res.month    = ent.month;
        res.day      = ent.day;
      end
      expected_results.push_back(res);
    endfunction

    // Compare one result transfer with the oldest expectation
    function void check_result(logic accepted, logic [1:0] status, logic [TAG_BITS-1:0] tag,
                               logic [MonthBits-1:0] month, logic [DayBits-1:0] day);
      result_t exp_res;
      if (expected_results.size() == 0) begin
        fail_count++;
        if (fail_count <= ReportLimit)
          $display("ERROR %0t: unexpected result acc=%0b st=%0d tag=%h m=%0d d=%0d",
                   $realtime, accepted, status, tag, month, day);
        return;
      end
      exp_res = expected_results.pop_front();
      if (accepted !== exp_res.accepted || status !== exp_res.status ||
          tag !== exp_res.tag || month !== exp_res.month || day !== exp_res.day) begin
        fail_count++;
        if (fail_count <= ReportLimit) begin
          $write("ERROR %0t: expected acc=%0b st=%0d tag=%h m=%0d d=%0d, ", $realtime,
                 exp_res.accepted, exp_res.status, exp_res.tag, exp_res.month,
                 exp_res.day);
          $display("got acc=%0b st=%0d tag=%h m=%0d d=%0d",
                   accepted, status, tag, month, day);
        end
      end
    endfunction
  endclass

  logic                 clk_i           = 1'b0;
  logic                 rst_ni          = 1'b0;
  logic                 in_valid_i      = 1'b0;
  logic                 in_stall_o;
  logic                 op_i            = 1'b0;
  logic [MonthBits-1:0] due_month_i     = '0;
  logic [DayInBits-1:0] due_day_i       = '0;
  logic [LenBits-1:0]   course_length_i = '0;
  logic [TAG_BITS-1:0]  item_tag_i      = '0;
  logic                 out_valid_o;
  logic                 out_stall_i     = 1'b0;
  logic                 accepted_o;
  logic [1:0]           status_o;
  logic [TAG_BITS-1:0]  out_tag_o;
  logic [MonthBits-1:0] out_month_o;
  logic [DayBits-1:0]   out_day_o;

  queue_scoreboard board = new();
  int unsigned     items_sent = 0;
  bit              steady     = 1'b0;

  due_date_priority_queue_top #(
    .DEPTH   (DEPTH),
    .TAG_BITS(TAG_BITS)
  ) u_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .op_i           (op_i),
    .due_month_i    (due_month_i),
    .due_day_i      (due_day_i),
    .course_length_i(course_length_i),
    .item_tag_i     (item_tag_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .accepted_o     (accepted_o),
    .status_o       (status_o),
    .out_tag_o      (out_tag_o),
    .out_month_o    (out_month_o),
    .out_day_o      (out_day_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Offer one request, with random idle cycles ahead of it, and hold it until transfer
  task automatic send_request(op_e op, logic [MonthBits-1:0] month,
                              logic [DayInBits-1:0] day, logic [LenBits-1:0] len,
                              logic [TAG_BITS-1:0] tag);
    while (!steady && $urandom_range(99) < 38) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i      <= 1'b1;
    op_i            <= op;
    due_month_i     <= month;
    due_day_i       <= day;
    course_length_i <= len;
    item_tag_i      <= tag;
    do @(posedge clk_i); while (in_stall_o);
    board.note_request(op, month, day, len, tag);
    items_sent++;
  endtask

  // Take results, with random stalls and one long hold-off
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && out_valid_o && !out_stall_i)
        board.check_result(accepted_o, status_o, out_tag_o, out_month_o, out_day_o);
      if (!hold_done && items_sent >= 300) begin
        hold_done = 1'b1;
        hold_left = 200;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (steady) begin
        out_stall_i <= 1'b0;
      end else begin
        out_stall_i <= ($urandom_range(99) < 38);
      end
    end
  end

  // End the run when no transfer happens for too long
  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < QuietLimit) begin
      @(posedge clk_i);
      if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
        quiet = 0;
      else
        quiet++;
    end
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    op_e                  op;
    logic [MonthBits-1:0] month;
    logic [DayInBits-1:0] day;
    logic [LenBits-1:0]   len;
    logic [TAG_BITS-1:0]  tag;
    int unsigned          phase_left;
    bit                   filling;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty dequeue, each kind of bad entry, then fill past full
    send_request(OpDequeue, '0, '0, '0, '0);
    send_request(OpEnqueue, 4'd13, 6'd5, 8'd3, 16'h0013);
    send_request(OpEnqueue, 4'd15, 6'd5, 8'd3, 16'h0015);
    send_request(OpEnqueue, 4'd3, 6'd32, 8'd3, 16'h0032);
    send_request(OpEnqueue, 4'd3, 6'd63, 8'd3, 16'h0063);
    send_request(OpEnqueue, 4'd3, 6'd5, 8'd0, 16'h0100);
    send_request(OpEnqueue, 4'd3, 6'd5, 8'd13, 16'h0113);
    send_request(OpEnqueue, 4'd3, 6'd5, 8'd255, 16'h01ff);
    for (int i = 0; i <= DEPTH; i++) begin
      if (i == 0)
        send_request(OpEnqueue, 4'd12, 6'd31, 8'd12, 16'hffff);
      else if (i == 1)
        send_request(OpEnqueue, 4'd0, 6'd0, 8'd1, 16'h0000);
      else if (i % 3 == 0)
        send_request(OpEnqueue, 4'd6, 6'd15, 8'(1 + i % 12), 16'(16'h1000 + i));
      else
        send_request(OpEnqueue, 4'((i * 5) % 13), 6'((i * 11) % 32), 8'(1 + i % 12),
                     16'(16'h1000 + i));
    end

    // Random: alternate filling and draining phases, mostly well-formed entries
    filling    = 1'b0;
    phase_left = 0;
    for (int n = 0; n < RandomItems; n++) begin
      steady = (n >= 650 && n < 850);
      if (n == 550) begin
        in_valid_i <= 1'b0;
        @(posedge clk_i);
        while (board.pending() != 0) @(posedge clk_i);
      end
      if (phase_left == 0) begin
        filling    = ~filling;
        phase_left = $urandom_range(60, 20);
      end
      phase_left--;
      tag = TAG_BITS'($urandom);
      if ($urandom_range(99) < (filling ? 75 : 30)) begin
        op = OpEnqueue;
        if ($urandom_range(99) < 15) begin
          month = MonthBits'($urandom);
          day   = DayInBits'($urandom);
          len   = LenBits'($urandom);
        end else begin
          // crowd dates together now and then to exercise equal-date order
          if ($urandom_range(99) < 40) begin
            month = MonthBits'($urandom_range(2, 0));
            day   = DayInBits'($urandom_range(2, 0));
          end else begin
            month = MonthBits'($urandom_range(12, 0));
            day   = DayInBits'($urandom_range(31, 0));
          end
          len = LenBits'($urandom_range(12, 1));
        end
      end else begin
        op    = OpDequeue;
        month = MonthBits'($urandom);
        day   = DayInBits'($urandom);
        len   = LenBits'($urandom);
      end
      send_request(op, month, day, len, tag);
    end
    steady     = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding results, then watch for strays
    while (board.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
    if (board.fail_count == 0 && board.pending() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
